>>> hdl/frnl_pkg.sv
// Shared constants and types for the Fresnel reflectance pipeline.
`default_nettype none
package frnl_pkg;

    localparam int DEF_COMPONENT_BITS = 16;
    localparam int INDEX_BITS         = 16;
    localparam int REFL_BITS          = 16;
    localparam int SQRT_STEPS         = 32;
    localparam int DIV_STEPS          = 16;

    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [15:0] REFL_ONE   = 16'h8000;
    localparam logic [16:0] RATIO_ONE  = 17'h1_0000;

    // travels alongside the square root stages
    typedef struct packed {
        logic        tir;
        logic [15:0] n1;
        logic [62:0] np;
        logic [46:0] ns;
    } frnl_sq_side_t;

    // travels alongside the divider stages
    typedef struct packed {
        logic tir;
        logic full_p;
        logic full_s;
    } frnl_div_side_t;

endpackage
`default_nettype wire

>>> hdl/frnl_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module frnl_isqrt
    import frnl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [62:0]   in_x,
    input  frnl_sq_side_t      in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output frnl_sq_side_t      out_side
);

    logic [63:0]   x_reg    [SQRT_STEPS];
    logic [63:0]   r_reg    [SQRT_STEPS];
    logic          v_reg    [SQRT_STEPS];
    frnl_sq_side_t side_reg [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - i));
        logic [63:0]   xi;
        logic [63:0]   ri;
        logic          vi;
        frnl_sq_side_t si;
        logic [63:0]   trial;

        if (i == 0)
        begin : g_first
            assign xi = {1'b0, in_x};
            assign ri = '0;
            assign vi = in_valid;
            assign si = in_side;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign ri = r_reg[i-1];
            assign vi = v_reg[i-1];
            assign si = side_reg[i-1];
        end

        assign trial = ri + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (xi >= trial)
                begin
                    x_reg[i] <= xi - trial;
                    r_reg[i] <= (ri >> 1) + BIT;
                end
                else
                begin
                    x_reg[i] <= xi;
                    r_reg[i] <= ri >> 1;
                end
                side_reg[i] <= si;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = r_reg[SQRT_STEPS-1][31:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

>>> hdl/frnl_div_pair.sv
// Two pipelined restoring dividers giving 16 fraction bits each.
`default_nettype none
module frnl_div_pair
    import frnl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [63:0]   num_p,
    input  wire logic [63:0]   den_p,
    input  wire logic [63:0]   num_s,
    input  wire logic [63:0]   den_s,
    input  frnl_div_side_t     in_side,
    output logic               out_valid,
    output logic [15:0]        q_p,
    output logic [15:0]        q_s,
    output frnl_div_side_t     out_side
);

    logic [64:0]    remp_reg [DIV_STEPS];
    logic [64:0]    rems_reg [DIV_STEPS];
    logic [63:0]    denp_reg [DIV_STEPS];
    logic [63:0]    dens_reg [DIV_STEPS];
    logic [15:0]    qp_reg   [DIV_STEPS];
    logic [15:0]    qs_reg   [DIV_STEPS];
    logic           v_reg    [DIV_STEPS];
    frnl_div_side_t side_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_stage
        logic [64:0]    rp_i;
        logic [64:0]    rs_i;
        logic [63:0]    dp_i;
        logic [63:0]    ds_i;
        logic [15:0]    qp_i;
        logic [15:0]    qs_i;
        logic           v_i;
        frnl_div_side_t s_i;
        logic [64:0]    rp2;
        logic [64:0]    rs2;

        if (i == 0)
        begin : g_first
            assign rp_i = {1'b0, num_p};
            assign rs_i = {1'b0, num_s};
            assign dp_i = den_p;
            assign ds_i = den_s;
            assign qp_i = '0;
            assign qs_i = '0;
            assign v_i  = in_valid;
            assign s_i  = in_side;
        end
        else
        begin : g_next
            assign rp_i = remp_reg[i-1];
            assign rs_i = rems_reg[i-1];
            assign dp_i = denp_reg[i-1];
            assign ds_i = dens_reg[i-1];
            assign qp_i = qp_reg[i-1];
            assign qs_i = qs_reg[i-1];
            assign v_i  = v_reg[i-1];
            assign s_i  = side_reg[i-1];
        end

        // remainder stays below the divisor, so one shift fits in 65 bits
        assign rp2 = {rp_i[63:0], 1'b0};
        assign rs2 = {rs_i[63:0], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rp2 >= {1'b0, dp_i})
                begin
                    remp_reg[i] <= rp2 - {1'b0, dp_i};
                    qp_reg[i]   <= {qp_i[14:0], 1'b1};
                end
                else
                begin
                    remp_reg[i] <= rp2;
                    qp_reg[i]   <= {qp_i[14:0], 1'b0};
                end
                if (rs2 >= {1'b0, ds_i})
                begin
                    rems_reg[i] <= rs2 - {1'b0, ds_i};
                    qs_reg[i]   <= {qs_i[14:0], 1'b1};
                end
                else
                begin
                    rems_reg[i] <= rs2;
                    qs_reg[i]   <= {qs_i[14:0], 1'b0};
                end
                denp_reg[i] <= dp_i;
                dens_reg[i] <= ds_i;
                side_reg[i] <= s_i;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign q_p       = qp_reg[DIV_STEPS-1];
    assign q_s       = qs_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hdl/fresnel_reflectance.sv
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// Takes one query per clock while the output is not stalled. A query accepted
// shows up on m_tvalid after 57 register stages, most of them in the 32-stage
// square root and the two 16-stage dividers running side by side. Any stall on
// the output side freezes the whole pipeline, so nothing is dropped or repeated.
// |D.N| is used without normalizing the inputs, and total internal reflection
// returns 1.0 with the flag in m_tuser.
`default_nettype none
module fresnel_reflectance
    import frnl_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to
    input  wire logic [((6*COMPONENT_BITS+2*INDEX_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // reflectance
    output logic [REFL_BITS-1:0] m_tdata,
    // total_internal
    output logic      m_tuser
);

    localparam int CB  = COMPONENT_BITS;
    localparam int PW  = 2 * CB;
    localparam int F2  = 2 * (CB - 1);
    localparam int SHR = (F2 >= 30) ? F2 - 30 : 0;
    localparam int SHL = (F2 >= 30) ? 0 : 30 - F2;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: component products
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic [15:0]          n1_1_reg, n2_1_reg;
    logic                 v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= $signed(s_tdata[0*CB +: CB]) * $signed(s_tdata[3*CB +: CB]);
            p1_reg   <= $signed(s_tdata[1*CB +: CB]) * $signed(s_tdata[4*CB +: CB]);
            p2_reg   <= $signed(s_tdata[2*CB +: CB]) * $signed(s_tdata[5*CB +: CB]);
            n1_1_reg <= s_tdata[6*CB +: 16];
            n2_1_reg <= s_tdata[6*CB+16 +: 16];
        end
    end

    // stage 2: dot product, cosine, index squares
    function automatic logic signed [33:0] to_q30(input logic signed [PW-1:0] p);
        logic signed [63:0] pe;
        pe = 64'(p);
        if (F2 >= 30)
            return 34'(pe >>> SHR);
        else
            return 34'(pe <<< SHL);
    endfunction

    logic signed [33:0] dot;
    logic [33:0]        mag;
    logic [30:0]        c_next;
    logic [30:0]        c_2_reg;
    logic [15:0]        n1_2_reg;
    logic [31:0]        n1sq_2_reg, n2sq_2_reg;
    logic               v2_reg;

    always_comb
    begin
        dot    = to_q30(p0_reg) + to_q30(p1_reg) + to_q30(p2_reg);
        mag    = dot[33] ? 34'(-dot) : 34'(dot);
        c_next = (mag > {3'b0, ONE_Q30}) ? ONE_Q30 : mag[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_2_reg    <= c_next;
            n1_2_reg   <= n1_1_reg;
            n1sq_2_reg <= n1_1_reg * n1_1_reg;
            n2sq_2_reg <= n2_1_reg * n2_1_reg;
        end
    end

    // stage 3: sine squared and n1*c
    logic [61:0] csq;
    logic [30:0] s2_3_reg, c_3_reg;
    logic [15:0] n1_3_reg;
    logic [31:0] n1sq_3_reg, n2sq_3_reg;
    logic [46:0] ns_3_reg;
    logic        v3_reg;

    assign csq = c_2_reg * c_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_3_reg   <= ONE_Q30 - csq[60:30];
            c_3_reg    <= c_2_reg;
            n1_3_reg   <= n1_2_reg;
            n1sq_3_reg <= n1sq_2_reg;
            n2sq_3_reg <= n2sq_2_reg;
            ns_3_reg   <= n1_2_reg * c_2_reg;
        end
    end

    // stage 4: n1^2 * s2
    logic [62:0] lhs_4_reg;
    logic [30:0] c_4_reg;
    logic [15:0] n1_4_reg;
    logic [31:0] n2sq_4_reg;
    logic [46:0] ns_4_reg;
    logic        v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_4_reg  <= n1sq_3_reg * s2_3_reg;
            c_4_reg    <= c_3_reg;
            n1_4_reg   <= n1_3_reg;
            n2sq_4_reg <= n2sq_3_reg;
            ns_4_reg   <= ns_3_reg;
        end
    end

    // stage 5: total internal reflection test, discriminant, n2^2*c
    logic [62:0]   rhs;
    logic          tir;
    logic [62:0]   k_5_reg;
    frnl_sq_side_t side_5_reg;
    logic          v5_reg;

    assign rhs = {1'b0, n2sq_4_reg, 30'b0};
    assign tir = lhs_4_reg > rhs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_5_reg        <= tir ? '0 : rhs - lhs_4_reg;
            side_5_reg.tir <= tir;
            side_5_reg.n1  <= n1_4_reg;
            side_5_reg.np  <= n2sq_4_reg * c_4_reg;
            side_5_reg.ns  <= ns_4_reg;
        end
    end

    // square root stages
    logic          vq;
    logic [31:0]   root;
    frnl_sq_side_t side_q;

    frnl_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_x      (k_5_reg),
        .in_side   (side_5_reg),
        .out_valid (vq),
        .out_root  (root),
        .out_side  (side_q)
    );

    // stage 6: n1 * S
    logic [62:0] n1sk_6_reg, np_6_reg;
    logic [46:0] sk_6_reg, ns_6_reg;
    logic        tir_6_reg;
    logic        v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= vq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1sk_6_reg <= {48'(side_q.n1) * 48'(root), 15'b0};
            sk_6_reg   <= {root, 15'b0};
            np_6_reg   <= side_q.np;
            ns_6_reg   <= side_q.ns;
            tir_6_reg  <= side_q.tir;
        end
    end

    // stage 7: numerators and denominators
    logic [63:0]    dp, nump;
    logic [47:0]    ds, nums;
    logic [63:0]    nump_7_reg, dp_7_reg, nums_7_reg, ds_7_reg;
    frnl_div_side_t dside_7_reg;
    logic           v7_reg;

    always_comb
    begin
        dp   = {1'b0, np_6_reg} + {1'b0, n1sk_6_reg};
        nump = (np_6_reg >= n1sk_6_reg) ? {1'b0, np_6_reg - n1sk_6_reg}
                                        : {1'b0, n1sk_6_reg - np_6_reg};
        ds   = {1'b0, ns_6_reg} + {1'b0, sk_6_reg};
        nums = (ns_6_reg >= sk_6_reg) ? {1'b0, ns_6_reg - sk_6_reg}
                                      : {1'b0, sk_6_reg - ns_6_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nump_7_reg         <= nump;
            dp_7_reg           <= dp;
            nums_7_reg         <= 64'(nums);
            ds_7_reg           <= 64'(ds);
            // zero denominator or ratio of one: magnitude 1.0
            dside_7_reg.full_p <= (dp == '0) || (nump >= dp);
            dside_7_reg.full_s <= (ds == '0) || (nums >= ds);
            dside_7_reg.tir    <= tir_6_reg;
        end
    end

    // divider stages
    logic           vd;
    logic [15:0]    qp, qs;
    frnl_div_side_t dside;

    frnl_div_pair u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num_p     (nump_7_reg),
        .den_p     (dp_7_reg),
        .num_s     (nums_7_reg),
        .den_s     (ds_7_reg),
        .in_side   (dside_7_reg),
        .out_valid (vd),
        .q_p       (qp),
        .q_s       (qs),
        .out_side  (dside)
    );

    // stage 8: squares and sum
    logic [16:0] rp, rs;
    logic [34:0] sum_8_reg;
    logic        tir_8_reg;
    logic        v8_reg;

    assign rp = dside.full_p ? RATIO_ONE : {1'b0, qp};
    assign rs = dside.full_s ? RATIO_ONE : {1'b0, qs};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_8_reg <= 35'(rp) * 35'(rp) + 35'(rs) * 35'(rs);
            tir_8_reg <= dside.tir;
        end
    end

    // output register: round half up to Q.15 and saturate
    logic [34:0]          rounded;
    logic [16:0]          refl;
    logic [REFL_BITS-1:0] refl_next;
    logic [REFL_BITS-1:0] refl_reg;
    logic                 tir_out_reg;

    always_comb
    begin
        rounded = sum_8_reg + 35'h2_0000;
        refl    = rounded[34:18];
        if (tir_8_reg || refl > {1'b0, REFL_ONE})
            refl_next = REFL_ONE;
        else
            refl_next = refl[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            refl_reg    <= refl_next;
            tir_out_reg <= tir_8_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = refl_reg;
    assign m_tuser  = tir_out_reg;

endmodule
`default_nettype wire

>>> hdl/frnl_checker.sv
// Port-level checks for the Fresnel reflectance block and their binding.
`default_nettype none
module frnl_checker
    import frnl_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [REFL_BITS-1:0] m_tdata,
    input wire logic                 m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == REFL_ONE)
        else $error("total internal reflection without full reflectance");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= REFL_ONE)
        else $error("reflectance above 1.0");

    // with an empty output the pipeline must keep taking transactions
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an accepted transaction while draining keeps the pipeline moving
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("input taken during output stall");

endmodule

bind fresnel_reflectance frnl_checker u_frnl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/tb_fresnel_reflectance.sv
// Testbench for fresnel_reflectance: random and directed queries checked against a predictor.
`default_nettype none
module tb_fresnel_reflectance;
    import frnl_pkg::*;

    localparam int CB = 16;
    localparam int DW = ((6*CB+2*INDEX_BITS+7)/8)*8;
    localparam int LIMIT = 5000;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } refl_res_t;

    class refl_scoreboard;
        refl_res_t pending[$];
        int errors = 0;
        int checked = 0;
        int tir_seen = 0;

        function automatic longint fl_q30(longint a, longint b);
            // Q1.15 * Q1.15 is already Q.30
            return a * b;
        endfunction

        function automatic longint unsigned isqrt(longint unsigned x);
            longint unsigned r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0)
            begin
                if (x >= r + bt)
                begin
                    x = x - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r = r >> 1;
                bt = bt >> 2;
            end
            return r;
        endfunction

        function automatic longint unsigned quot16(longint unsigned num, longint unsigned den);
            longint unsigned q, rem;
            q = 0;
            rem = num;
            if (den == 0 || rem >= den)
                return 64'd65536;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q = q | 64'd1;
                end
            end
            return q;
        endfunction

        function automatic void note_query(logic [DW-1:0] d);
            longint dot;
            longint unsigned n1, n2, c, s2, lhs, rhs, s, sk, np, dp, ns, ds, rp, rs, sm, r;
            refl_res_t e;
            dot = fl_q30(longint'($signed(d[15:0])), longint'($signed(d[63:48])))
                + fl_q30(longint'($signed(d[31:16])), longint'($signed(d[79:64])))
                + fl_q30(longint'($signed(d[47:32])), longint'($signed(d[95:80])));
            n1 = 64'(d[111:96]);
            n2 = 64'(d[127:112]);
            c = (dot < 0) ? -dot : dot;
            if (c > (64'd1 << 30)) c = 64'd1 << 30;
            s2 = (64'd1 << 30) - ((c * c) >> 30);
            lhs = n1 * n1 * s2;
            rhs = n2 * n2 * (64'd1 << 30);
            if (lhs > rhs)
            begin
                e.refl = REFL_ONE;
                e.tir = 1'b1;
            end
            else
            begin
                s = isqrt(rhs - lhs);
                sk = s << 15;
                np = n2 * n2 * c;
                dp = np + n1 * sk;
                rp = quot16((np >= n1 * sk) ? np - n1 * sk : n1 * sk - np, dp);
                ns = n1 * c;
                ds = ns + sk;
                rs = quot16((ns >= sk) ? ns - sk : sk - ns, ds);
                sm = rp * rp + rs * rs;
                r = (sm + (64'd1 << 17)) >> 18;
                if (r > 64'd32768) r = 64'd32768;
                e.refl = r[15:0];
                e.tir = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function automatic void check_result(logic [15:0] refl, logic tir);
            refl_res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result refl=%0d tir=%0d", refl, tir);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (tir) tir_seen++;
            if (refl !== e.refl)
            begin
                $error("reflectance: expected %0d actual %0d", e.refl, refl);
                errors++;
            end
            if (tir !== e.tir)
            begin
                $error("total_internal: expected %0d actual %0d", e.tir, tir);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [15:0] m_tdata;
    logic m_tuser;

    refl_scoreboard sb = new();
    bit sender_done = 0;
    bit calm = 0;
    bit hold_off = 0;
    int idle_cnt = 0;
    int sent = 0;

    fresnel_reflectance DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    function automatic logic [DW-1:0] pack_q(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
        logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [15:0] n1, logic [15:0] n2);
        return {n2, n1, nz, ny, nx, dz, dy, dx};
    endfunction

    function automatic logic [15:0] rnd_index();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(16384, 16384 + 64));
            default: return 16'($urandom_range(16384, 65535));
        endcase
    endfunction

    // one transaction; idles first at random unless in a calm stretch
    task automatic send(logic [DW-1:0] d);
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_query(d);
        sent++;
    endtask

    task automatic send_random();
        int ax, ay, az, m;
        logic [15:0] nx, ny, nz;
        if ($urandom_range(0, 4) == 0)
            send({$urandom, $urandom, $urandom, $urandom});
        else
        begin
            // roughly unit normal along a random axis, random direction with |x|+|y|+|z| = 32767
            m = $urandom_range(0, 2);
            nx = (m == 0) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                          : 16'($urandom_range(0, 4000));
            ny = (m == 1) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                          : 16'($urandom_range(0, 4000));
            nz = (m == 2) ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                          : 16'($urandom_range(0, 4000));
            ax = $urandom_range(0, 32767);
            ay = $urandom_range(0, 32767 - ax);
            az = 32767 - ax - ay;
            send(pack_q(16'($urandom_range(0, 1) ? -ax : ax), 16'($urandom_range(0, 1) ? -ay : ay),
                16'($urandom_range(0, 1) ? -az : az), nx, ny, nz, rnd_index(), rnd_index()));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        calm = 1;
        // normal incidence, equal and unequal indices
        send(pack_q(16'h7fff, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h4000, 16'h4000));
        send(pack_q(16'h7fff, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h4000, 16'h6000));
        // grazing: total internal reflection, and k exactly zero
        send(pack_q(16'h0, 16'h7fff, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h6000, 16'h4000));
        send(pack_q(16'h0, 16'h7fff, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h4000, 16'h4000));
        send(pack_q(16'h0, 16'h7fff, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h4000, 16'hffff));
        // non-unit vectors saturate c
        send(pack_q(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h4000, 16'h8000));
        send(pack_q(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h4000));
        send(pack_q(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h4000, 16'h4000));
        // zero vectors and zero / tiny indices
        send(pack_q(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h8000));
        send(pack_q(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
        send(pack_q(16'h7fff, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0));
        send(pack_q(16'h7fff, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h4000));
        send(pack_q(16'h7fff, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h4000, 16'h0));
        send(pack_q(16'h0, 16'h7fff, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h4000, 16'h0));
        send(pack_q(16'h5a82, 16'h5a82, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'hffff, 16'h4000));
        send(pack_q(16'h5a82, 16'h5a82, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0001, 16'hffff));
        send(pack_q(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        calm = 0;
        for (int i = 0; i < 650; i++)
        begin
            calm = (i >= 200 && i < 300);
            send_random();
        end
        s_tvalid <= 1'b0;
        sender_done = 1;
    end

    // receiver with random stalls, one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (sent >= 350 && sent < 360 && !hold_off)
            begin
                hold_off = 1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            m_tready <= (calm || $urandom_range(0, 99) >= 17);
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        wait (sender_done);
        wait (sb.pending.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d queries sent, %0d results checked, %0d with total internal reflection",
            sent, sb.checked, sb.tir_seen);
        $display("covered edge, grazing, zero-index and random-geometry queries under stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
hdl/frnl_pkg.sv
hdl/frnl_isqrt.sv
hdl/frnl_div_pair.sv
hdl/fresnel_reflectance.sv
hdl/frnl_checker.sv
tb/tb_fresnel_reflectance.sv
